// ----- rtl/dsmc_pkg.sv -----
// Package for the differential stepper move controller.
// Holds the command and result item types, mode and register codes, and the coil pattern table.
// No dependencies.
package dsmc_pkg;

	localparam int AMOUNT_W = 14;
	localparam int SCALE_W  = 32;
	localparam int DIV_W    = 16;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;

	// Command modes
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_MOVE = 2'd1;
	localparam logic [1:0] MODE_TURN = 2'd2;
	localparam logic [1:0] MODE_STOP = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVISOR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_MOVE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_TURN_DIR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_SCALE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_SCALE      = 3'd4;

	// Register reset values
	localparam logic [DIV_W-1:0]   TICK_DIVISOR_RST = 16'd1;
	localparam logic [SCALE_W-1:0] MOVE_SCALE_RST   = 32'd17005700;
	localparam logic [SCALE_W-1:0] TURN_SCALE_RST   = 32'd1855050;

	typedef struct packed {
		logic [1:0]          mode;
		logic                direction;
		logic [AMOUNT_W-1:0] amount;
	} cmd_item_t;

	typedef struct packed {
		logic [3:0] right_coils;
		logic [3:0] left_coils;
		logic       busy_res;
	} res_item_t;

	// Half-step coil pattern for each of the eight phases
	function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
		logic [3:0] pat;
		case (phase)
			3'd0: pat = 4'd1;
			3'd1: pat = 4'd3;
			3'd2: pat = 4'd2;
			3'd3: pat = 4'd6;
			3'd4: pat = 4'd4;
			3'd5: pat = 4'd12;
			3'd6: pat = 4'd8;
			3'd7: pat = 4'd9;
			default: pat = 4'd0;
		endcase
		return pat;
	endfunction

endpackage

// ----- rtl/differential_stepper_move_controller.sv -----
// A command is captured in the input register, and its result then in the result register.
// Throughput: one command or tick per cycle while the result register is free or drains;
// step count scaling is one 14x32 multiply between the input and state/result registers.
// Reset (arst_n low, asynchronous): motors off, count zero, phases zero, both directions
// forward, coils zero, configuration registers at their defaults, no item held.
// Depends on dsmc_pkg.
module differential_stepper_move_controller #(
	parameter int FRACTION_BITS = 16,
	parameter int COUNT_WIDTH   = 30
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  dsmc_pkg::cmd_item_t         cmd,
	output logic                        res_valid,
	input  logic                        res_ready,
	output dsmc_pkg::res_item_t         res,
	input  logic                        cfg_we,
	input  logic [dsmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dsmc_pkg::CFG_W-1:0]  cfg_data
);
	import dsmc_pkg::*;

	localparam int PROD_W = AMOUNT_W + SCALE_W;

	// Configuration registers
	logic [DIV_W-1:0]   tick_divisor_q;
	logic               invert_move_q;
	logic               invert_turn_dir_q;
	logic [SCALE_W-1:0] move_scale_q;
	logic [SCALE_W-1:0] turn_scale_q;

	// Input register
	cmd_item_t cmd_s1;
	logic      valid_s1;
	logic      advance_s1;

	// Motion state
	logic [COUNT_WIDTH-1:0] steps_left_q, steps_left_d;
	logic [DIV_W-1:0]       tick_count_q, tick_count_d;
	logic                   motors_on_q, motors_on_d;
	logic [2:0]             right_phase_q, right_phase_d;
	logic [2:0]             left_phase_q, left_phase_d;
	logic                   right_fwd_q, right_fwd_d;
	logic                   left_fwd_q, left_fwd_d;
	logic [3:0]             right_coil_q, right_coil_d;
	logic [3:0]             left_coil_q, left_coil_d;

	// Result register
	res_item_t res_q;
	logic      res_valid_q;

	// Scaling and tick datapath
	logic [SCALE_W-1:0]     scale_sel;
	logic [PROD_W-1:0]      product;
	logic [PROD_W-1:0]      shifted;
	logic [COUNT_WIDTH-1:0] scaled_steps;
	logic [DIV_W-1:0]       div_eff;
	logic [DIV_W-1:0]       count_inc;
	logic                   fire;
	logic                   dir_eff;
	logic [COUNT_WIDTH-1:0] steps_dec;

	// Handshake: the input register moves on whenever the result register is free or drains
	assign advance_s1 = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready  = !valid_s1 || advance_s1;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_divisor_q    <= TICK_DIVISOR_RST;
			invert_move_q     <= 1'b0;
			invert_turn_dir_q <= 1'b0;
			move_scale_q      <= MOVE_SCALE_RST;
			turn_scale_q      <= TURN_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICK_DIVISOR:    tick_divisor_q    <= cfg_data[DIV_W-1:0];
				REG_INVERT_MOVE:     invert_move_q     <= cfg_data[0];
				REG_INVERT_TURN_DIR: invert_turn_dir_q <= cfg_data[0];
				REG_MOVE_SCALE:      move_scale_q      <= cfg_data[SCALE_W-1:0];
				REG_TURN_SCALE:      turn_scale_q      <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the incoming command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

	// Scale the amount to a step count, truncate and saturate
	always_comb begin
		scale_sel = (cmd_s1.mode == MODE_TURN) ? turn_scale_q : move_scale_q;
		product   = PROD_W'(cmd_s1.amount) * PROD_W'(scale_sel);
		shifted   = product >> FRACTION_BITS;
		if (|shifted[PROD_W-1:COUNT_WIDTH]) begin
			scaled_steps = '1;
		end else begin
			scaled_steps = shifted[COUNT_WIDTH-1:0];
		end
	end

	// Tick divider compare
	always_comb begin
		div_eff   = (tick_divisor_q == '0) ? DIV_W'(1) : tick_divisor_q;
		count_inc = tick_count_q + DIV_W'(1);
		fire      = (count_inc >= div_eff);
		steps_dec = steps_left_q - COUNT_WIDTH'(1);
		dir_eff   = (cmd_s1.mode == MODE_TURN) ? (cmd_s1.direction ^ invert_turn_dir_q)
		                                       : (cmd_s1.direction ^ invert_move_q);
	end

	// Next motion state for the item in the input register
	always_comb begin
		steps_left_d  = steps_left_q;
		tick_count_d  = tick_count_q;
		motors_on_d   = motors_on_q;
		right_phase_d = right_phase_q;
		left_phase_d  = left_phase_q;
		right_fwd_d   = right_fwd_q;
		left_fwd_d    = left_fwd_q;
		right_coil_d  = right_coil_q;
		left_coil_d   = left_coil_q;
		case (cmd_s1.mode)
			MODE_TICK: begin
				if (steps_left_q != '0) begin
					steps_left_d = steps_dec;
					tick_count_d = fire ? '0 : count_inc;
					if (motors_on_q && fire) begin
						right_coil_d  = coil_pattern(right_phase_q);
						left_coil_d   = coil_pattern(left_phase_q);
						right_phase_d = right_fwd_q ? right_phase_q + 3'd1 : right_phase_q - 3'd1;
						left_phase_d  = left_fwd_q ? left_phase_q + 3'd1 : left_phase_q - 3'd1;
					end
					// Last step: release the coils
					if (steps_dec == '0) begin
						motors_on_d  = 1'b0;
						right_coil_d = 4'd0;
						left_coil_d  = 4'd0;
					end
				end
			end
			MODE_MOVE: begin
				steps_left_d = scaled_steps;
				right_fwd_d  = !dir_eff;
				left_fwd_d   = dir_eff;
				motors_on_d  = 1'b1;
			end
			MODE_TURN: begin
				steps_left_d = scaled_steps;
				right_fwd_d  = !dir_eff;
				left_fwd_d   = !dir_eff;
				motors_on_d  = 1'b1;
			end
			default: begin
				steps_left_d = '0;
				motors_on_d  = 1'b0;
				right_coil_d = 4'd0;
				left_coil_d  = 4'd0;
			end
		endcase
	end

	// Advance the motion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_left_q  <= '0;
			tick_count_q  <= '0;
			motors_on_q   <= 1'b0;
			right_phase_q <= 3'd0;
			left_phase_q  <= 3'd0;
			right_fwd_q   <= 1'b1;
			left_fwd_q    <= 1'b1;
			right_coil_q  <= 4'd0;
			left_coil_q   <= 4'd0;
		end else if (advance_s1) begin
			steps_left_q  <= steps_left_d;
			tick_count_q  <= tick_count_d;
			motors_on_q   <= motors_on_d;
			right_phase_q <= right_phase_d;
			left_phase_q  <= left_phase_d;
			right_fwd_q   <= right_fwd_d;
			left_fwd_q    <= left_fwd_d;
			right_coil_q  <= right_coil_d;
			left_coil_q   <= left_coil_d;
		end
	end

	// Hold the result until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			res_q.right_coils <= right_coil_d;
			res_q.left_coils  <= left_coil_d;
			res_q.busy_res    <= (steps_left_d != '0);
		end
	end

endmodule
